// File: src/uigfr_pkg.sv
`timescale 1ns / 1ps
// Package for the idle-gap frame receiver: item codes, register indexes,
// field widths and the delivery command type. Depends on nothing.
package uigfr_pkg;

  localparam int BUFFER_DEPTH_DEF = 64;

  localparam int OP_W      = 2;
  localparam int DATA_W    = 8;
  localparam int IDX_W     = 6;
  localparam int LEN_W     = 7;
  localparam int GAP_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;

  localparam int CMD_FIFO_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_BYTE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_FLUSH = 2'd2
  } op_e;

  localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PASSTHROUGH = 1'b1;

  localparam logic [GAP_W-1:0] GAP_TICKS_RST = 16'd5;

  // One frame handed from the front to the back for delivery.
  typedef struct packed {
    logic             dropped;
    logic [LEN_W-1:0] length;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EMIT,
    BK_DROP
  } bk_state_e;

endpackage

// File: src/uigfr_front.sv
`timescale 1ns / 1ps
// Front end: accepts items, keeps the frame state, gap counter and config
// registers, writes the frame store and queues deliveries. Uses uigfr_pkg.
module uigfr_front import uigfr_pkg::*; #(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
  localparam int AW = $clog2(BUFFER_DEPTH),
  localparam int CW = $clog2(BUFFER_DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 busy_i,
  input  logic [OP_W-1:0]      operation_i,
  input  logic [DATA_W-1:0]    rx_byte_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output logic                 wr_en_o,
  output logic [AW-1:0]        wr_addr_o,
  output logic [DATA_W-1:0]    wr_data_o,
  output logic                 push_o,
  output cmd_t                 cmd_o
);

  logic [CW-1:0]    count_q, count_d;
  logic             ovf_q, ovf_d;
  logic             pend_q, pend_d;
  logic [GAP_W-1:0] gap_q, gap_d, gap_dec;
  logic [GAP_W-1:0] gap_ticks_q;
  logic             passthrough_q;
  logic             accept;
  logic             full;

  assign accept  = in_valid_i && !busy_i;
  assign full    = (count_q == CW'(BUFFER_DEPTH));
  assign gap_dec = (gap_q != '0) ? gap_q - GAP_W'(1) : gap_q;

  assign wr_addr_o = count_q[AW-1:0];
  assign wr_data_o = rx_byte_i;
  assign cmd_o.dropped = ovf_q;
  assign cmd_o.length  = LEN_W'(count_q);

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    pend_d  = pend_q;
    gap_d   = gap_q;
    wr_en_o = 1'b0;
    push_o  = 1'b0;
    if (accept) begin
      unique case (op_e'(operation_i))
        OP_BYTE: begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            wr_en_o = 1'b1;
            count_d = count_q + CW'(1);
          end
          pend_d = 1'b1;
          gap_d  = gap_ticks_q;
        end
        OP_TICK: begin
          gap_d = gap_dec;
          if (gap_dec == '0 && pend_q && !passthrough_q) begin
            // an empty frame without overflow is cleared silently
            push_o  = ovf_q || (count_q != '0);
            count_d = '0;
            ovf_d   = 1'b0;
            pend_d  = 1'b0;
          end
        end
        OP_FLUSH: begin
          count_d = '0;
          ovf_d   = 1'b0;
          pend_d  = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      pend_q  <= 1'b0;
      gap_q   <= '0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
      pend_q  <= pend_d;
      gap_q   <= gap_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_ticks_q   <= GAP_TICKS_RST;
      passthrough_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GAP_TICKS:   gap_ticks_q   <= cfg_wdata_i;
        REG_PASSTHROUGH: passthrough_q <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

endmodule

// File: src/uigfr_cmd_fifo.sv
`timescale 1ns / 1ps
// Short queue of delivery commands between the front and the back.
// Uses cmd_t from uigfr_pkg.
module uigfr_cmd_fifo import uigfr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  localparam int PW = $clog2(CMD_FIFO_DEPTH);
  localparam int NW = $clog2(CMD_FIFO_DEPTH + 1);

  cmd_t          mem_q [CMD_FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [NW-1:0] fill_q;
  logic          do_push, do_pop;

  assign valid_o = (fill_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && (fill_q != NW'(CMD_FIFO_DEPTH));
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + NW'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - NW'(1);
      end
    end
  end

endmodule

// File: src/uigfr_back.sv
`timescale 1ns / 1ps
// Back end: holds the frame store and plays a queued frame out, one result a
// cycle while out_stall_i is low, through a registered output. Uses uigfr_pkg.
module uigfr_back import uigfr_pkg::*; #(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
  localparam int AW = $clog2(BUFFER_DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic              cmd_valid_i,
  input  cmd_t              cmd_i,
  output logic              pop_o,
  output logic              busy_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DATA_W-1:0] frame_byte_o,
  output logic [IDX_W-1:0]  byte_index_o,
  output logic [LEN_W-1:0]  frame_length_o,
  output logic              dropped_o,
  output logic              last_o
);

  logic [DATA_W-1:0] mem_q [BUFFER_DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;

  bk_state_e         state_q, state_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              is_last;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign is_last = (LEN_W'(idx_q) + LEN_W'(1) == len_q);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    len_d   = len_q;
    pop_o   = 1'b0;
    rd_en   = 1'b0;
    rd_addr = idx_q;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          pop_o = 1'b1;
          len_d = cmd_i.length;
          if (cmd_i.dropped) begin
            state_d = BK_DROP;
          end else if (cmd_i.length != '0) begin
            rd_en   = 1'b1;
            rd_addr = '0;
            idx_d   = '0;
            state_d = BK_EMIT;
          end
        end
      end
      BK_EMIT: begin
        if (!out_stall_i) begin
          if (is_last) begin
            state_d = BK_IDLE;
          end else begin
            // fetch the next byte as this one leaves
            rd_en   = 1'b1;
            rd_addr = idx_q + AW'(1);
            idx_d   = idx_q + AW'(1);
          end
        end
      end
      BK_DROP: begin
        if (!out_stall_i) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      idx_q   <= '0;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
    end
  end

  assign busy_o         = (state_q != BK_IDLE);
  assign out_valid_o    = (state_q != BK_IDLE);
  assign frame_byte_o   = (state_q == BK_EMIT) ? rdata_q : '0;
  assign byte_index_o   = (state_q == BK_EMIT) ? IDX_W'(idx_q) : '0;
  assign frame_length_o = len_q;
  assign dropped_o      = (state_q == BK_DROP);
  assign last_o         = (state_q == BK_DROP) || ((state_q == BK_EMIT) && is_last);

endmodule

// File: src/uart_idle_gap_frame_receiver_top.sv
`timescale 1ns / 1ps
// Idle-gap frame receiver: gathers received UART bytes into a frame that closes
// once gap_ticks tick items (at least one) pass with no new byte, then plays it out.
// Input items (operation_i: byte, tick or flush) are taken one per cycle
// while no delivery is outstanding. A tick that closes a frame queues a
// delivery; from the next cycle in_stall_o stays high until the frame is
// played out: one result per stored byte, or a single dropped result for a
// frame that overflowed. The frame store has a single read port, read once
// per result. A frame holds at most BUFFER_DEPTH bytes; later bytes mark it
// as overflowed. Registers: index 0 gap_ticks (reset 5), index 1 passthrough
// (reset 0, holds frames back while set). Write them only while idle.
// Depends on uigfr_pkg and the front, queue and back modules.
module uart_idle_gap_frame_receiver_top import uigfr_pkg::*; #(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [OP_W-1:0]      operation_i,
  input  logic [DATA_W-1:0]    rx_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [DATA_W-1:0]    frame_byte_o,
  output logic [IDX_W-1:0]     byte_index_o,
  output logic [LEN_W-1:0]     frame_length_o,
  output logic                 dropped_o,
  output logic                 last_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              push, pop, cmd_valid, back_busy, busy;
  cmd_t              push_cmd, head_cmd;

  // Hold input while a frame is queued or being played out: the store is
  // shared, so new bytes must not overwrite a frame still being read.
  assign busy       = cmd_valid || back_busy;
  assign in_stall_o = busy;

  uigfr_front #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .busy_i      (busy),
    .operation_i (operation_i),
    .rx_byte_i   (rx_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  uigfr_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .valid_o (cmd_valid),
    .cmd_o   (head_cmd)
  );

  uigfr_back #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .wr_en_i        (wr_en),
    .wr_addr_i      (wr_addr),
    .wr_data_i      (wr_data),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (head_cmd),
    .pop_o          (pop),
    .busy_o         (back_busy),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_byte_o   (frame_byte_o),
    .byte_index_o   (byte_index_o),
    .frame_length_o (frame_length_o),
    .dropped_o      (dropped_o),
    .last_o         (last_o)
  );

  // Results only appear while input is held back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("result offered while input open");

  // A dropped frame is one final result for a full store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && dropped_o) |->
      (last_o && frame_length_o == LEN_W'(BUFFER_DEPTH) && frame_byte_o == '0))
    else $error("malformed dropped result");

  // Byte positions stay inside the frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !dropped_o) |-> (LEN_W'(byte_index_o) < frame_length_o))
    else $error("byte index beyond frame length");

  // Until the last result is taken, the next cycle still offers a byte of the same frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_o) |=> (out_valid_o && !dropped_o))
    else $error("frame cut short");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Testbench for uart_idle_gap_frame_receiver_top: a directed table, then random frames,
// broken sequences and noise over several register settings, with every result transfer
// checked against a cycle-free predictor or typed row. Depends on uigfr_pkg, receiver RTL.
module testbench;
  import uigfr_pkg::*;

  // Operation code the block must ignore.
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  localparam int unsigned RANDOM_ITEMS    = 300;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned TAIL_CYCLES     = 16;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned IDLE_LIMIT      = 3000;
  localparam int unsigned REPORT_CAP      = 200;
  localparam int unsigned SCRIPT_ROWS     = 28;

  typedef struct packed {
    logic [DATA_W-1:0] frame_byte;
    logic [IDX_W-1:0]  byte_index;
    logic [LEN_W-1:0]  frame_length;
    logic              dropped;
    logic              last;
  } frame_out_t;

  localparam frame_out_t NO_RESULT = '0;

  // How a row of the directed table is handled: checked against the predictor, expected
  // to give nothing, expected to give the one result typed in the row, or a register write.
  typedef enum {ROW_PREDICT, ROW_QUIET, ROW_TYPED, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [1:0]  code;
    logic [15:0] value;
    frame_out_t  want;
  } script_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [OP_W-1:0]   operation_i;
  logic [DATA_W-1:0] rx_byte_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [DATA_W-1:0] frame_byte_o;
  logic [IDX_W-1:0]  byte_index_o;
  logic [LEN_W-1:0]  frame_length_o;
  logic              dropped_o;
  logic              last_o;
  logic              cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]  cfg_wdata_i;

  uart_idle_gap_frame_receiver_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_byte_o   (frame_byte_o),
    .byte_index_o   (byte_index_o),
    .frame_length_o (frame_length_o),
    .dropped_o      (dropped_o),
    .last_o         (last_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // Directed table. Typed rows give a single byte frame whose result is plain to see.
  script_row_t script [SCRIPT_ROWS] = '{
    // After reset: gap of five ticks, one zero byte, frame closes on the fifth tick.
    '{ROW_QUIET,   OP_BYTE,         16'h0000, NO_RESULT},
    '{ROW_QUIET,   OP_TICK,         16'h0000, NO_RESULT},
    '{ROW_QUIET,   OP_TICK,         16'h0000, NO_RESULT},
    '{ROW_QUIET,   OP_TICK,         16'h0000, NO_RESULT},
    '{ROW_QUIET,   OP_TICK,         16'h0000, NO_RESULT},
    '{ROW_TYPED,   OP_TICK,         16'h0000, '{8'h00, 6'd0, 7'd1, 1'b0, 1'b1}},
    // Gap of one tick, all-ones byte, two-byte frame.
    '{ROW_WRITE,   OP_W'(REG_GAP_TICKS),   16'd1,    NO_RESULT},
    '{ROW_QUIET,   OP_BYTE,         16'h00ff, NO_RESULT},
    '{ROW_QUIET,   OP_BYTE,         16'h005a, NO_RESULT},
    '{ROW_PREDICT, OP_TICK,         16'h0000, NO_RESULT},
    // Unknown operation, then a tick with nothing pending.
    '{ROW_QUIET,   OP_NONE,         16'h00a5, NO_RESULT},
    '{ROW_QUIET,   OP_TICK,         16'h0000, NO_RESULT},
    // Flush discards the frame; the tick that follows finds nothing.
    '{ROW_QUIET,   OP_BYTE,         16'h0012, NO_RESULT},
    '{ROW_QUIET,   OP_FLUSH,        16'h0000, NO_RESULT},
    '{ROW_QUIET,   OP_TICK,         16'h0000, NO_RESULT},
    // Zero gap: the very next tick delivers.
    '{ROW_WRITE,   OP_W'(REG_GAP_TICKS),   16'd0,    NO_RESULT},
    '{ROW_QUIET,   OP_BYTE,         16'h0080, NO_RESULT},
    '{ROW_TYPED,   OP_TICK,         16'h0000, '{8'h80, 6'd0, 7'd1, 1'b0, 1'b1}},
    // Held frame: nothing comes out until passthrough drops again.
    '{ROW_WRITE,   OP_W'(REG_PASSTHROUGH), 16'd1,    NO_RESULT},
    '{ROW_QUIET,   OP_BYTE,         16'h007f, NO_RESULT},
    '{ROW_QUIET,   OP_TICK,         16'h0000, NO_RESULT},
    '{ROW_QUIET,   OP_TICK,         16'h0000, NO_RESULT},
    '{ROW_WRITE,   OP_W'(REG_PASSTHROUGH), 16'd0,    NO_RESULT},
    '{ROW_TYPED,   OP_TICK,         16'h0000, '{8'h7f, 6'd0, 7'd1, 1'b0, 1'b1}},
    // Longest gap: one tick is far from enough, then flush the frame away.
    '{ROW_WRITE,   OP_W'(REG_GAP_TICKS),   16'hffff, NO_RESULT},
    '{ROW_QUIET,   OP_BYTE,         16'h00c3, NO_RESULT},
    '{ROW_QUIET,   OP_TICK,         16'h0000, NO_RESULT},
    '{ROW_QUIET,   OP_FLUSH,        16'h0000, NO_RESULT}
  };

  // Predictor state: its own copy of the frame and of both registers.
  logic [DATA_W-1:0] mirror_store [BUFFER_DEPTH_DEF];
  logic [LEN_W-1:0]  mirror_count;
  logic              mirror_ovf;
  logic              mirror_pend;
  logic [GAP_W-1:0]  mirror_gap;
  logic [GAP_W-1:0]  mirror_gap_ticks;
  logic              mirror_pass;

  frame_out_t step_out [$];  // results of the item just accepted
  frame_out_t frame_q [$];   // results still owed by the block

  bit          calm = 1'b0;
  bit          hold_off_req = 1'b0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned full_seen = 0;
  int unsigned dropped_seen = 0;
  int unsigned mismatches = 0;
  int unsigned phase = 0;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Work out what one accepted item does to the frame, and the results it gives.
  function automatic void receiver_step(input logic [OP_W-1:0] op,
                                        input logic [DATA_W-1:0] data);
    frame_out_t res;
    step_out.delete();
    case (op)
      OP_BYTE: begin
        if (mirror_count >= BUFFER_DEPTH_DEF) begin
          mirror_ovf = 1'b1;
        end else begin
          mirror_store[mirror_count] = data;
          mirror_count++;
        end
        mirror_pend = 1'b1;
        mirror_gap  = mirror_gap_ticks;
      end
      OP_TICK: begin
        if (mirror_gap != 0) mirror_gap--;
        if (mirror_gap == 0 && mirror_pend && !mirror_pass) begin
          if (mirror_ovf) begin
            res = '{8'h00, 6'd0, mirror_count, 1'b1, 1'b1};
            step_out.push_back(res);
          end else begin
            for (int i = 0; i < int'(mirror_count); i++) begin
              res.frame_byte   = mirror_store[i];
              res.byte_index   = IDX_W'(i);
              res.frame_length = mirror_count;
              res.dropped      = 1'b0;
              res.last         = (i + 1 == int'(mirror_count));
              step_out.push_back(res);
            end
          end
          mirror_count = '0;
          mirror_ovf   = 1'b0;
          mirror_pend  = 1'b0;
        end
      end
      OP_FLUSH: begin
        mirror_count = '0;
        mirror_ovf   = 1'b0;
        mirror_pend  = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // Idle length: mostly none or short, now and then long; none at all in calm stretches.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $error("%s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  // Offer one item, hold it until the transfer, then advance the predictor.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] data,
                           input bit to_queue);
    int unsigned idle;
    idle = pick_gap();
    if (idle != 0) begin
      in_valid_i <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    rx_byte_i   <= data;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    receiver_step(op, data);
    if (to_queue) foreach (step_out[k]) frame_q.push_back(step_out[k]);
    if (op != OP_NONE) items_sent++;
  endtask

  // Drop valid, wait for every owed result, then let the block go quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    if (idx == REG_GAP_TICKS) mirror_gap_ticks = value;
    else mirror_pass = value[0];
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // A well-formed frame: len random bytes, then enough ticks to close it. With hold set,
  // ask for the long receiver hold-off just before the closing ticks.
  task automatic send_frame(input int unsigned len, input bit hold);
    int unsigned ticks;
    repeat (len) send_item(OP_BYTE, DATA_W'($urandom_range(0, 255)), 1'b1);
    ticks = (mirror_gap_ticks > 20 ? 20 : int'(mirror_gap_ticks)) + $urandom_range(0, 1);
    if (hold) hold_off_req <= 1'b1;
    repeat (ticks) send_item(OP_TICK, DATA_W'($urandom_range(0, 255)), 1'b1);
  endtask

  // Main sequence: reset, directed table, random phases, drain.
  initial begin : stimulus
    int unsigned random_goal;
    int unsigned phase_start;
    int unsigned pick;
    int unsigned len_pick;
    int unsigned gap_sel;
    int unsigned pass_sel;
    in_valid_i  <= 1'b0;
    operation_i <= OP_BYTE;
    rx_byte_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_GAP_TICKS;
    cfg_wdata_i <= '0;
    rst_ni      <= 1'b0;
    mirror_count     = '0;
    mirror_ovf       = 1'b0;
    mirror_pend      = 1'b0;
    mirror_gap       = '0;
    mirror_gap_ticks = GAP_TICKS_RST;
    mirror_pass      = 1'b0;
    foreach (mirror_store[k]) mirror_store[k] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table.
    foreach (script[r]) begin
      case (script[r].kind)
        ROW_WRITE: begin
          settle();
          write_reg(script[r].code[CFG_IDX_W-1:0], script[r].value);
        end
        ROW_PREDICT: send_item(script[r].code, script[r].value[DATA_W-1:0], 1'b1);
        ROW_QUIET:   send_item(script[r].code, script[r].value[DATA_W-1:0], 1'b0);
        ROW_TYPED: begin
          send_item(script[r].code, script[r].value[DATA_W-1:0], 1'b0);
          frame_q.push_back(script[r].want);
        end
        default: ;
      endcase
    end

    // Random phases, each under its own register setting.
    random_goal = items_sent + RANDOM_ITEMS;
    while (items_sent < random_goal) begin
      settle();
      if (phase == 0) begin
        gap_sel  = 1;
        pass_sel = 0;
      end else begin
        gap_sel  = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        pass_sel = ($urandom_range(0, 4) == 0);
      end
      write_reg(REG_GAP_TICKS, CFG_W'(gap_sel));
      write_reg(REG_PASSTHROUGH, CFG_W'(pass_sel));
      calm = (phase != 0) && ($urandom_range(0, 3) == 0);
      phase_start = items_sent;
      if (phase == 0) begin
        // A full store under a long receiver hold-off, then one byte too many.
        send_frame(BUFFER_DEPTH_DEF, 1'b1);
        send_frame(BUFFER_DEPTH_DEF + 1, 1'b0);
      end
      while (items_sent - phase_start < 50) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          len_pick = $urandom_range(0, 19);
          if (len_pick < 16) send_frame($urandom_range(1, 8), 1'b0);
          else if (len_pick < 19) send_frame($urandom_range(9, BUFFER_DEPTH_DEF), 1'b0);
          else send_frame($urandom_range(BUFFER_DEPTH_DEF + 1, BUFFER_DEPTH_DEF + 4), 1'b0);
        end else if (pick < 80) begin
          // Broken frame: cut short by a flush, or left open with too few ticks.
          repeat ($urandom_range(1, 5))
            send_item(OP_BYTE, DATA_W'($urandom_range(0, 255)), 1'b1);
          if ($urandom_range(0, 1) == 1)
            send_item(OP_FLUSH, DATA_W'($urandom_range(0, 255)), 1'b1);
          else if (mirror_gap_ticks > 1)
            repeat ($urandom_range(1, int'(mirror_gap_ticks) - 1))
              send_item(OP_TICK, DATA_W'($urandom_range(0, 255)), 1'b1);
        end else begin
          repeat ($urandom_range(1, 6))
            send_item(OP_W'($urandom_range(0, 3)), DATA_W'($urandom_range(0, 255)), 1'b1);
        end
      end
      calm = 1'b0;
      phase++;
    end

    // Drain, then give the block time to show any stray transfer.
    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Sent %0d items over %0d random phases; checked %0d result transfers.",
             items_sent, phase, results_seen);
    $display("Full-store frames: %0d, dropped frames: %0d, mismatches: %0d.",
             full_seen, dropped_seen, mismatches);
    if (mismatches == 0 && frame_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Receiver stall: random bursts, plus one long hold-off on request, counted here.
  initial begin : out_stall_gen
    int unsigned burst;
    int unsigned hold_left;
    burst = 0;
    hold_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (hold_off_req) begin
        hold_off_req <= 1'b0;
        hold_left = HOLD_OFF_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else if (burst != 0) begin
        out_stall_i <= 1'b1;
        burst--;
      end else if ($urandom_range(0, 99) < 25) begin
        burst = pick_gap();
        out_stall_i <= (burst != 0);
        if (burst != 0) burst--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare each result transfer with the oldest owed result.
  always @(posedge clk_i) begin : result_check
    frame_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (frame_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $error("result with none owed: byte %0h index %0d length %0d dropped %0b last %0b",
                 frame_byte_o, byte_index_o, frame_length_o, dropped_o, last_o);
      end else begin
        want = frame_q.pop_front();
        check_field("frame_byte", 16'(want.frame_byte), 16'(frame_byte_o));
        check_field("byte_index", 16'(want.byte_index), 16'(byte_index_o));
        check_field("frame_length", 16'(want.frame_length), 16'(frame_length_o));
        check_field("dropped", 16'(want.dropped), 16'(dropped_o));
        check_field("last", 16'(want.last), 16'(last_o));
        if (want.dropped) dropped_seen++;
        else if (want.last && want.frame_length == LEN_W'(BUFFER_DEPTH_DEF)) full_seen++;
      end
    end
  end

  // Watchdog: end the run once nothing has moved on either side for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("No transfer for %0d cycles, giving up.", IDLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
